/* hw/rtl/i2a_pkg.sv */
`default_nettype none

package i2a_pkg;

	// operation codes
	localparam logic [1:0] OP_U32 = 2'd0;
	localparam logic [1:0] OP_S32 = 2'd1;
	localparam logic [1:0] OP_U64 = 2'd2;
	localparam logic [1:0] OP_S64 = 2'd3;

	// base limits and ascii constants
	localparam logic [4:0] BASE_MIN  = 5'd2;
	localparam logic [4:0] BASE_MAX  = 5'd16;
	localparam logic [4:0] BASE_DEC  = 5'd10;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ALPHA = 8'h57;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	// request and result payloads
	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] value;
		logic [4:0]  base;
	} number_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_t;

	// datapath actions of the control word
	localparam logic [3:0] ACT_NONE       = 4'd0;
	localparam logic [3:0] ACT_LOAD       = 4'd1;
	localparam logic [3:0] ACT_EMIT_MINUS = 4'd2;
	localparam logic [3:0] ACT_DIV_INIT   = 4'd3;
	localparam logic [3:0] ACT_DIV_STEP   = 4'd4;
	localparam logic [3:0] ACT_STORE      = 4'd5;
	localparam logic [3:0] ACT_READ       = 4'd6;
	localparam logic [3:0] ACT_EMIT_DIGIT = 4'd7;
	localparam logic [3:0] ACT_EMIT_ZERO  = 4'd8;

	// jump conditions of the control word
	localparam logic [2:0] CND_ALWAYS   = 3'd0;
	localparam logic [2:0] CND_NO_INPUT = 3'd1;
	localparam logic [2:0] CND_SPECIAL  = 3'd2;
	localparam logic [2:0] CND_NO_MINUS = 3'd3;
	localparam logic [2:0] CND_OUT_BUSY = 3'd4;
	localparam logic [2:0] CND_DIV_RUN  = 3'd5;
	localparam logic [2:0] CND_QUOT_NZ  = 3'd6;
	localparam logic [2:0] CND_COUNT_NZ = 3'd7;

	// program step addresses; some are referenced as jump targets
	localparam logic [3:0] PC_LOAD     = 4'd0;
	localparam logic [3:0] PC_SPECIAL  = 4'd1;
	localparam logic [3:0] PC_SIGN     = 4'd2;
	localparam logic [3:0] PC_MINUS    = 4'd3;
	localparam logic [3:0] PC_DIV_INIT = 4'd4;
	localparam logic [3:0] PC_DIV_STEP = 4'd5;
	localparam logic [3:0] PC_STORE    = 4'd6;
	localparam logic [3:0] PC_READ     = 4'd7;
	localparam logic [3:0] PC_EMIT     = 4'd8;
	localparam logic [3:0] PC_NEXT     = 4'd9;
	localparam logic [3:0] PC_DONE     = 4'd10;
	localparam logic [3:0] PC_ZERO     = 4'd11;
	localparam logic [3:0] PC_ZDONE    = 4'd12;

	typedef struct packed {
		logic [3:0] act;
		logic [2:0] cnd;
		logic [3:0] tgt;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic special;
		logic minus;
		logic out_busy;
		logic div_run;
		logic quot_nz;
		logic count_nz;
	} status_t;

	// microcode program
	function automatic ctrl_t rom(input logic [3:0] pc);
		ctrl_t w;
		case (pc)
			PC_LOAD:     w = '{ACT_LOAD,       CND_NO_INPUT, PC_LOAD};
			PC_SPECIAL:  w = '{ACT_NONE,       CND_SPECIAL,  PC_ZERO};
			PC_SIGN:     w = '{ACT_NONE,       CND_NO_MINUS, PC_DIV_INIT};
			PC_MINUS:    w = '{ACT_EMIT_MINUS, CND_OUT_BUSY, PC_MINUS};
			PC_DIV_INIT: w = '{ACT_DIV_INIT,   CND_ALWAYS,   PC_DIV_STEP};
			PC_DIV_STEP: w = '{ACT_DIV_STEP,   CND_DIV_RUN,  PC_DIV_STEP};
			PC_STORE:    w = '{ACT_STORE,      CND_QUOT_NZ,  PC_DIV_INIT};
			PC_READ:     w = '{ACT_READ,       CND_ALWAYS,   PC_EMIT};
			PC_EMIT:     w = '{ACT_EMIT_DIGIT, CND_OUT_BUSY, PC_EMIT};
			PC_NEXT:     w = '{ACT_NONE,       CND_COUNT_NZ, PC_READ};
			PC_DONE:     w = '{ACT_NONE,       CND_ALWAYS,   PC_LOAD};
			PC_ZERO:     w = '{ACT_EMIT_ZERO,  CND_OUT_BUSY, PC_ZERO};
			PC_ZDONE:    w = '{ACT_NONE,       CND_ALWAYS,   PC_LOAD};
			default:     w = '{ACT_NONE,       CND_ALWAYS,   PC_LOAD};
		endcase
		return w;
	endfunction

	// digit value to lower-case ascii
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = CHAR_ALPHA + {4'd0, d};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2a_ram.sv */
`default_nettype none

module i2a_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/i2a_seq.sv */
`default_nettype none

module i2a_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire i2a_pkg::status_t status,
	output i2a_pkg::ctrl_t        ctrl
);

	logic [3:0] pc_q;
	logic       jump;

	assign ctrl = i2a_pkg::rom(pc_q);

	// jump condition select
	always_comb begin
		case (ctrl.cnd)
			i2a_pkg::CND_ALWAYS:   jump = 1'b1;
			i2a_pkg::CND_NO_INPUT: jump = !status.in_valid;
			i2a_pkg::CND_SPECIAL:  jump = status.special;
			i2a_pkg::CND_NO_MINUS: jump = !status.minus;
			i2a_pkg::CND_OUT_BUSY: jump = status.out_busy;
			i2a_pkg::CND_DIV_RUN:  jump = status.div_run;
			i2a_pkg::CND_QUOT_NZ:  jump = status.quot_nz;
			i2a_pkg::CND_COUNT_NZ: jump = status.count_nz;
			default:               jump = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= i2a_pkg::PC_LOAD;
		end else if (jump) begin
			pc_q <= ctrl.tgt;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_radix.sv */
// Steps: load and test the request, emit a leading minus for a negative decimal value, then
// per digit run the shared divider at 8 quotient bits a cycle, plus set-up and store, then
// read and emit each character and close; zero or a bad base emits a lone zero instead.
// Requests: one at a time; the load step returns through the closing steps after the last
// character is handed to the output register, which may still be waiting to be taken.
// Reset: asynchronous, active low; sequencer returns to the load step, no output valid.
`default_nettype none

module integer_to_ascii_radix #(
	parameter int MAX_DIGITS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             number_valid,
	output logic                  number_stall,
	input  wire i2a_pkg::number_t number,
	output logic                  text_valid,
	input  wire logic             text_stall,
	output i2a_pkg::text_t        text
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	i2a_pkg::ctrl_t   ctrl;
	i2a_pkg::status_t status;

	logic [63:0]   quot_q;
	logic [4:0]    base_q;
	logic [3:0]    rem_q;
	logic [2:0]    bit_q;
	logic [CW-1:0] count_q;
	logic          minus_q;
	logic          special_q;
	i2a_pkg::text_t out_q;
	logic          out_valid_q;

	logic          out_busy;
	logic          accept;
	logic          emit;
	i2a_pkg::text_t emit_data;

	logic          wide;
	logic [63:0]   ext_val;
	logic          neg;
	logic          minus_d;
	logic          special_d;
	logic [63:0]   mag;

	logic [63:0]   div_q;
	logic [3:0]    div_r;
	logic [4:0]    div_t;

	logic          ram_we;
	logic          ram_re;
	logic [CW-1:0] rd_idx;
	logic [3:0]    ram_rdata;

	// microcode sequencer
	i2a_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// digit store
	i2a_ram #(
		.WIDTH (4),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (rem_q),
		.re    (ram_re),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	// handshakes
	assign out_busy     = out_valid_q && text_stall;
	assign number_stall = (ctrl.act != i2a_pkg::ACT_LOAD);
	assign accept       = number_valid && !number_stall;
	assign text_valid   = out_valid_q;
	assign text         = out_q;

	// status back to the sequencer
	assign status.in_valid = number_valid;
	assign status.special  = special_q;
	assign status.minus    = minus_q;
	assign status.out_busy = out_busy;
	assign status.div_run  = (bit_q != 3'd7);
	assign status.quot_nz  = (quot_q != 64'd0);
	assign status.count_nz = (count_q != '0);

	// request decode: width, sign and magnitude
	assign wide      = number.operation[1];
	assign ext_val   = wide ? number.value : {32'd0, number.value[31:0]};
	assign neg       = number.operation[0] && (wide ? ext_val[63] : ext_val[31]);
	assign minus_d   = neg && (number.base == i2a_pkg::BASE_DEC);
	assign special_d = (ext_val == 64'd0) || (number.base < i2a_pkg::BASE_MIN)
		|| (number.base > i2a_pkg::BASE_MAX);
	assign mag       = wide ? (64'd0 - ext_val) : {32'd0, 32'd0 - ext_val[31:0]};

	// eight restoring division steps on the top quotient byte
	always_comb begin
		div_q = quot_q;
		div_r = rem_q;
		div_t = '0;
		for (int i = 0; i < 8; i++) begin
			div_t = {div_r, div_q[63]};
			div_q = {div_q[62:0], 1'b0};
			if (div_t >= base_q) begin
				div_t    = div_t - base_q;
				div_q[0] = 1'b1;
			end
			div_r = div_t[3:0];
		end
	end

	// digit store access
	assign ram_we = (ctrl.act == i2a_pkg::ACT_STORE) && (count_q < CW'(MAX_DIGITS));
	assign ram_re = (ctrl.act == i2a_pkg::ACT_READ);
	assign rd_idx = count_q - CW'(1);

	// character for the output register
	always_comb begin
		emit      = 1'b0;
		emit_data = '{character: i2a_pkg::CHAR_ZERO, last: 1'b1};
		case (ctrl.act)
			i2a_pkg::ACT_EMIT_MINUS: begin
				emit      = !out_busy;
				emit_data = '{character: i2a_pkg::CHAR_MINUS, last: 1'b0};
			end
			i2a_pkg::ACT_EMIT_DIGIT: begin
				emit      = !out_busy;
				emit_data = '{character: i2a_pkg::digit_char(ram_rdata),
					last: (count_q == CW'(1))};
			end
			i2a_pkg::ACT_EMIT_ZERO: begin
				emit      = !out_busy;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// datapath control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			bit_q     <= '0;
			minus_q   <= 1'b0;
			special_q <= 1'b0;
		end else begin
			case (ctrl.act)
				i2a_pkg::ACT_LOAD: begin
					if (accept) begin
						count_q   <= '0;
						minus_q   <= minus_d;
						special_q <= special_d;
					end
				end
				i2a_pkg::ACT_DIV_INIT: begin
					bit_q <= '0;
				end
				i2a_pkg::ACT_DIV_STEP: begin
					bit_q <= bit_q + 3'd1;
				end
				i2a_pkg::ACT_STORE: begin
					if (count_q < CW'(MAX_DIGITS)) begin
						count_q <= count_q + CW'(1);
					end
				end
				i2a_pkg::ACT_EMIT_DIGIT: begin
					if (!out_busy) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// quotient, base and remainder
	always_ff @(posedge clk) begin
		case (ctrl.act)
			i2a_pkg::ACT_LOAD: begin
				if (accept) begin
					quot_q <= minus_d ? mag : ext_val;
					base_q <= number.base;
				end
			end
			i2a_pkg::ACT_DIV_INIT: begin
				rem_q <= '0;
			end
			i2a_pkg::ACT_DIV_STEP: begin
				quot_q <= div_q;
				rem_q  <= div_r;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_data;
		end
	end

	// a new result appears only from an emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(ctrl.act) == i2a_pkg::ACT_EMIT_MINUS
			|| $past(ctrl.act) == i2a_pkg::ACT_EMIT_DIGIT
			|| $past(ctrl.act) == i2a_pkg::ACT_EMIT_ZERO))
		else $error("result without emit step");

	// an accepted request starts with an empty digit store
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == '0))
		else $error("digit count not cleared on request");

	// digit count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_DIGITS))
		else $error("digit count overflow");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_busy |=> $stable(out_q))
		else $error("stalled result overwritten");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 100;
	localparam int REPORT_LIMIT  = 10;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             number_valid = 1'b0;
	logic             number_stall;
	i2a_pkg::number_t number = '0;
	logic             text_valid;
	logic             text_stall = 1'b0;
	i2a_pkg::text_t   text;

	// characters still owed by the block, oldest first
	i2a_pkg::text_t expected_text[$];
	int             error_count = 0;

	// idling controls, in percent per decision
	int tx_idle_pct = 30;
	int rx_idle_pct = 30;

	// long hold-off of the text side, raised by bumping the ticket
	int hold_ticket = 0;

	integer_to_ascii_radix dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.number_valid (number_valid),
		.number_stall (number_stall),
		.number       (number),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text         (text)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lower-case ascii for one digit value
	function automatic logic [7:0] glyph(input logic [3:0] d);
		string glyphs;
		glyphs = "0123456789abcdef";
		return glyphs[d];
	endfunction

	// spell out one number and queue its characters
	function automatic void spell_number(input i2a_pkg::number_t n);
		logic [63:0]    mag;
		logic [63:0]    radix;
		logic [63:0]    rem;
		logic [3:0]     digits [64];
		logic           wide;
		logic           negative;
		logic           minus;
		int             count;
		i2a_pkg::text_t t;
		wide = n.operation[1];
		mag = wide ? n.value : {32'd0, n.value[31:0]};
		negative = n.operation[0] && (wide ? mag[63] : mag[31]);
		// zero and bases outside 2..16 give a lone zero
		if (mag == 64'd0 || n.base < i2a_pkg::BASE_MIN || n.base > i2a_pkg::BASE_MAX) begin
			t.character = i2a_pkg::CHAR_ZERO;
			t.last = 1'b1;
			expected_text.push_back(t);
			return;
		end
		minus = negative && n.base == i2a_pkg::BASE_DEC;
		if (minus) begin
			mag = -mag;
			if (!wide) begin
				mag[63:32] = 32'd0;
			end
		end
		radix = {59'd0, n.base};
		count = 0;
		while (mag != 64'd0) begin
			rem = mag % radix;
			digits[count] = rem[3:0];
			count++;
			mag = mag / radix;
		end
		if (minus) begin
			t.character = i2a_pkg::CHAR_MINUS;
			t.last = 1'b0;
			expected_text.push_back(t);
		end
		for (int i = count - 1; i >= 0; i--) begin
			t.character = glyph(digits[i]);
			t.last = (i == 0);
			expected_text.push_back(t);
		end
	endfunction

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct) begin
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// predict on every accepted request, check every accepted character
	always @(posedge clk) begin
		i2a_pkg::text_t want;
		if (number_valid && !number_stall) begin
			spell_number(number);
		end
		if (text_valid && !text_stall) begin
			if (expected_text.size() == 0) begin
				if (error_count < REPORT_LIMIT) begin
					$display("%0t: unexpected character %h last %b", $realtime,
						text.character, text.last);
				end
				error_count++;
			end else begin
				want = expected_text.pop_front();
				if (text.character !== want.character || text.last !== want.last) begin
					if (error_count < REPORT_LIMIT) begin
						$display("%0t: mismatch character exp %h got %h, last exp %b got %b",
							$realtime, want.character, text.character, want.last,
							text.last);
					end
					error_count++;
				end
			end
		end
	end

	// text side stall: random bursts, plus long hold-offs on request
	always @(posedge clk) begin
		int hold_served;
		int hold_left;
		int burst_left;
		if (hold_ticket != hold_served) begin
			hold_served = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			text_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			text_stall <= 1'b1;
		end else begin
			burst_left = pick_gap(rx_idle_pct);
			if (burst_left > 0) begin
				burst_left--;
				text_stall <= 1'b1;
			end else begin
				text_stall <= 1'b0;
			end
		end
	end

	// offer one request, wait until it is taken
	task automatic send_number(input i2a_pkg::number_t n);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			number_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_valid <= 1'b1;
		number <= n;
		do @(posedge clk); while (number_stall);
	endtask

	// stop offering and wait for every owed character
	task automatic wait_drained();
		number_valid <= 1'b0;
		do @(posedge clk); while (expected_text.size() != 0);
	endtask

	function automatic i2a_pkg::number_t make_number(input logic [1:0] op,
			input logic [63:0] v, input logic [4:0] b);
		i2a_pkg::number_t n;
		n.operation = op;
		n.value = v;
		n.base = b;
		return n;
	endfunction

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: v = v >> $urandom_range(1, 63);
			1: v = v >> $urandom_range(44, 63);
			2: v = 64'd1 << $urandom_range(0, 63);
			3: v = (64'd1 << $urandom_range(1, 63)) - 64'd1;
			4: v = v | 64'h8000_0000_8000_0000;
			5: v = {32'd0, $urandom_range(0, 3)};
			default: ;
		endcase
		return v;
	endfunction

	function automatic i2a_pkg::number_t random_number();
		logic [4:0] b;
		case ($urandom_range(0, 9))
			0, 1: b = i2a_pkg::BASE_DEC;
			2:    b = 5'($urandom_range(0, 31));
			default: b = 5'($urandom_range(i2a_pkg::BASE_MIN, i2a_pkg::BASE_MAX));
		endcase
		return make_number(2'($urandom_range(0, 3)), random_value(), b);
	endfunction

	// corner values, every operation, every special case
	task automatic test_directed();
		send_number(make_number(i2a_pkg::OP_U32, 64'd0, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_S32, 64'hffff_ffff_0000_0000, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_U64, 64'd0, 5'd2));
		send_number(make_number(i2a_pkg::OP_S64, 64'd0, i2a_pkg::BASE_MAX));
		send_number(make_number(i2a_pkg::OP_U64, 64'd12345, 5'd0));
		send_number(make_number(i2a_pkg::OP_U64, 64'd12345, 5'd1));
		send_number(make_number(i2a_pkg::OP_S64, 64'hffff_ffff_ffff_ffff, 5'd17));
		send_number(make_number(i2a_pkg::OP_U32, 64'd7, 5'd31));
		send_number(make_number(i2a_pkg::OP_U64, 64'hffff_ffff_ffff_ffff, 5'd2));
		send_number(make_number(i2a_pkg::OP_U64, 64'hffff_ffff_ffff_ffff, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_U64, 64'hffff_ffff_ffff_ffff, 5'd3));
		send_number(make_number(i2a_pkg::OP_U64, 64'hfedc_ba98_7654_3210, i2a_pkg::BASE_MAX));
		send_number(make_number(i2a_pkg::OP_S32, 64'h0000_0000_8000_0000, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_S64, 64'h8000_0000_0000_0000, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_S32, 64'h1234_5678_ffff_cfc7, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_S64, 64'hffff_ffff_ffff_ffff, i2a_pkg::BASE_MAX));
		send_number(make_number(i2a_pkg::OP_S32, 64'h0000_0000_ffff_ffff, 5'd2));
		send_number(make_number(i2a_pkg::OP_U32, 64'hdead_beef_ffff_ffff, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_S64, 64'h7fff_ffff_ffff_ffff, i2a_pkg::BASE_DEC));
		send_number(make_number(i2a_pkg::OP_S32, 64'h0000_0000_7fff_ffff, 5'd8));
		send_number(make_number(i2a_pkg::OP_U32, 64'd1, 5'd7));
		send_number(make_number(i2a_pkg::OP_S64, 64'hffff_ffff_ffff_fff6, 5'd9));
		send_number(make_number(i2a_pkg::OP_U32, 64'd15, i2a_pkg::BASE_MAX));
		wait_drained();
	endtask

	// bulk random requests with idling on both sides
	task automatic test_random(input int count);
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		repeat (count) send_number(random_number());
		wait_drained();
	endtask

	// no idling at all on either side
	task automatic test_streaming(input int count);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (count) send_number(random_number());
		wait_drained();
		tx_idle_pct = 30;
		rx_idle_pct = 30;
	endtask

	// text side held off while requests keep coming
	task automatic test_backpressure(input int count);
		tx_idle_pct = 0;
		hold_ticket <= hold_ticket + 1;
		repeat (count) send_number(random_number());
		wait_drained();
		tx_idle_pct = 30;
	endtask

	// sender pauses until everything owed has come
	task automatic test_pause(input int rounds);
		repeat (rounds) begin
			repeat ($urandom_range(1, 3)) send_number(random_number());
			wait_drained();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(120);
		test_backpressure(15);
		test_streaming(30);
		test_pause(10);
		test_random(45);
		test_backpressure(10);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
